FILE: design/cksum_pkg.sv
`timescale 1ns / 1ps
package cksum_pkg;

	localparam logic [31:0] CrcPoly = 32'h04C11DB7;
	localparam int QueueDepth = 4;
	localparam int QueueAw = $clog2(QueueDepth);

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] checksum;
		logic [63:0] byte_count;
	} result_t;

	typedef enum logic {
		OP_DATA   = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	// one byte through the msb-first crc
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
		end
		return c;
	endfunction

endpackage

FILE: design/cksum_front.sv
`timescale 1ns / 1ps
module cksum_front import cksum_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_pop
);

	cmd_t                entry_q [QueueDepth];
	logic [QueueAw-1:0]  wr_ptr_q;
	logic [QueueAw-1:0]  rd_ptr_q;
	logic [QueueAw:0]    cnt_q;
	logic                push;
	logic                pop;
	cmd_t                cmd_in;

	assign item_stall = (cnt_q == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (cnt_q != '0);
	assign pop        = cmd_pop && cmd_valid;
	assign cmd        = entry_q[rd_ptr_q];

	// classify
	always_comb begin
		cmd_in.op   = item.action ? OP_FINISH : OP_DATA;
		cmd_in.data = item.data_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QueueAw'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QueueAw'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QueueAw+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QueueAw+1)'(1);
			end
		end
	end

endmodule

FILE: design/cksum_back.sv
`timescale 1ns / 1ps
module cksum_back import cksum_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	typedef enum logic {
		ST_DATA,
		ST_LEN
	} state_t;

	state_t      state_q;
	logic [31:0] crc_q;
	logic [63:0] count_q;
	logic [63:0] rest_q;
	logic        out_valid_q;
	result_t     out_q;
	logic        out_free;
	logic        emit;

	assign cmd_pop      = cmd_valid && (state_q == ST_DATA);
	assign out_free     = !out_valid_q || !result_stall;
	assign emit         = (state_q == ST_LEN) && (rest_q == 64'd0) && out_free;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DATA;
			crc_q       <= '0;
			count_q     <= '0;
			rest_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_DATA: begin
					if (cmd_valid) begin
						if (cmd.op == OP_FINISH) begin
							rest_q  <= count_q;
							state_q <= ST_LEN;
						end else begin
							crc_q   <= crc_feed(crc_q, cmd.data);
							count_q <= count_q + 64'd1;
						end
					end
				end
				ST_LEN: begin
					// length appended lsb first, stop when nothing is left
					if (rest_q != 64'd0) begin
						crc_q  <= crc_feed(crc_q, rest_q[7:0]);
						rest_q <= rest_q >> 8;
					end else if (emit) begin
						out_q.checksum   <= ~crc_q;
						out_q.byte_count <= count_q;
						crc_q            <= '0;
						count_q          <= '0;
						state_q          <= ST_DATA;
					end
				end
			endcase
		end
	end

endmodule

FILE: design/posix_cksum_crc32.sv
`timescale 1ns / 1ps
// POSIX cksum CRC-32 (poly 04C11DB7, msb first, zero start). A data word is
// taken every cycle while the queue is not full and feeds one byte through
// the CRC; a finish word appends the byte count lsb first, stopping at the
// last nonzero byte, then returns the inverted CRC and the 64-bit count and
// clears both. Words pass through a four-word queue into the CRC sequencer,
// which feeds the significant count bytes (0 to 8) of a finish word one by
// one. The result sits in an output register, so the block keeps taking words
// while a result waits, until a later finish word stalls and the queue fills.
module posix_cksum_crc32 import cksum_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	cksum_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	cksum_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: design/cksum_checker.sv
`timescale 1ns / 1ps
module cksum_checker import cksum_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// empty message gives all ones
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.byte_count == 64'd0) |-> (result.checksum == 32'hFFFFFFFF))
		else $error("wrong checksum for empty message");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result word right after reset");

endmodule

bind posix_cksum_crc32 cksum_checker u_cksum_checker (.*);
